[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic property, disabled while reset is low
`define XPR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// same-cycle implication
`define XPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	`XPR_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// next-cycle implication
`define XPR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	`XPR_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

[sv/xpr_pkg.sv]
// ----------------------------------------------------------------------------
// xpr_pkg
// Types, codes and the CRC-16 step shared by the XMODEM receiver.
// ----------------------------------------------------------------------------
package xpr_pkg;

	localparam logic [1:0] OP_BYTE     = 2'd0;
	localparam logic [1:0] OP_TIMEOUT  = 2'd1;
	localparam logic [1:0] OP_LINE_ERR = 2'd2;
	localparam logic [1:0] OP_START    = 2'd3;

	localparam logic [7:0] SYM_SOH = 8'h01;
	localparam logic [7:0] SYM_EOT = 8'h04;
	localparam logic [7:0] SYM_ACK = 8'h06;
	localparam logic [7:0] SYM_NAK = 8'h15;
	localparam logic [7:0] SYM_CRC = 8'h43;

	localparam logic [2:0] VERDICT_GOOD    = 3'd0;
	localparam logic [2:0] VERDICT_DUP     = 3'd1;
	localparam logic [2:0] VERDICT_END     = 3'd2;
	localparam logic [2:0] VERDICT_BAD     = 3'd3;
	localparam logic [2:0] VERDICT_LINE    = 3'd4;
	localparam logic [2:0] VERDICT_TIMEOUT = 3'd5;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [8:0]  COMPL_SUM = 9'h0ff;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic [6:0] payload_index;
		logic       packet_done;
		logic [2:0] verdict;
		logic       reply_valid;
		logic [7:0] reply_code;
		logic [7:0] last_block;
	} result_t;

	typedef enum logic [1:0] {
		K_BYTE,
		K_TIMEOUT,
		K_LINE_ERR,
		K_START
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic       is_soh;
		logic       is_eot;
		logic [7:0] rx_byte;
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BLOCK,
		PH_COMPL,
		PH_PAYLOAD,
		PH_TRAIL_HI,
		PH_TRAIL_LO
	} phase_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		c = acc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

[sv/xmodem_packet_receiver.sv]
// ----------------------------------------------------------------------------
// xmodem_packet_receiver
// XMODEM receive framing: block, complement and CRC-16 or checksum checks.
//
// Input channel item_valid/item_ready carries one item_t per transaction:
// a received byte, a timeout, a line error or a transfer start. Every item
// yields exactly one result_t on result_valid/result_ready, in order:
// payload bytes with their index, verdicts with the ACK/NAK reply, and the
// 'C'/NAK reply on a start. cfg_valid/cfg_ready writes crc_mode; write it
// only while no transaction is in flight.
// The input register loads on the accepting edge, the command then enters
// the two-entry queue and after that the result register. With result_ready
// held high one item per cycle is sustained; the framing and CRC step for one
// byte is combinational in the back end, ahead of the result register.
// Reset clears framing, the block number and crc_mode (checksum mode).
// When result_ready is low the result register holds, the queue fills, and
// item_ready falls once the queue and input register are both occupied.
// ----------------------------------------------------------------------------
module xmodem_packet_receiver #(
	parameter int PAYLOAD_BYTES = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  xpr_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_ready,
	output xpr_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);

	logic          crc_mode_q;
	logic          f_valid;
	logic          f_ready;
	xpr_pkg::cmd_t f_cmd;
	logic          b_valid;
	logic          b_ready;
	xpr_pkg::cmd_t b_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			crc_mode_q <= cfg_data;
		end
	end

	xpr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cmd_valid  (f_valid),
		.cmd_ready  (f_ready),
		.cmd        (f_cmd)
	);

	xpr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_cmd),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_cmd)
	);

	xpr_back #(
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.crc_mode     (crc_mode_q),
		.cmd_valid    (b_valid),
		.cmd_ready    (b_ready),
		.cmd          (b_cmd),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

[sv/xpr_front.sv]
// ----------------------------------------------------------------------------
// xpr_front
// Input stage: takes items, classifies the operation and the framing byte.
// ----------------------------------------------------------------------------
module xpr_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  xpr_pkg::item_t  item,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output xpr_pkg::cmd_t   cmd
);

	logic          valid_s1;
	xpr_pkg::cmd_t cmd_s1;
	xpr_pkg::cmd_t cls;

	always_comb begin
		cls.is_soh  = (item.rx_byte == xpr_pkg::SYM_SOH);
		cls.is_eot  = (item.rx_byte == xpr_pkg::SYM_EOT);
		cls.rx_byte = item.rx_byte;
		unique case (item.op)
			xpr_pkg::OP_BYTE:     cls.kind = xpr_pkg::K_BYTE;
			xpr_pkg::OP_TIMEOUT:  cls.kind = xpr_pkg::K_TIMEOUT;
			xpr_pkg::OP_LINE_ERR: cls.kind = xpr_pkg::K_LINE_ERR;
			xpr_pkg::OP_START:    cls.kind = xpr_pkg::K_START;
			default:              cls.kind = xpr_pkg::K_BYTE;
		endcase
	end

	assign item_ready = !valid_s1 || cmd_ready;
	assign cmd_valid  = valid_s1;
	assign cmd        = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			cmd_s1 <= cls;
		end
	end

endmodule

[sv/xpr_queue.sv]
// ----------------------------------------------------------------------------
// xpr_queue
// Short FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xpr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  xpr_pkg::cmd_t  push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output xpr_pkg::cmd_t  pop_data
);

	localparam int PW = (xpr_pkg::QUEUE_DEPTH > 1) ? $clog2(xpr_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(xpr_pkg::QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(xpr_pkg::QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(xpr_pkg::QUEUE_DEPTH);

	xpr_pkg::cmd_t   slot_q [xpr_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	`XPR_ASSERT(a_count_range, clk, arst_n, count_q <= FULL_CNT, "queue count out of range")

endmodule

[sv/xpr_back.sv]
// ----------------------------------------------------------------------------
// xpr_back
// Framing state, block and trailer checks, verdicts and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xpr_back #(
	parameter int PAYLOAD_BYTES = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              crc_mode,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  xpr_pkg::cmd_t     cmd,
	output logic              result_valid,
	input  logic              result_ready,
	output xpr_pkg::result_t  result
);

	localparam int CW = $clog2(PAYLOAD_BYTES);
	localparam logic [CW-1:0] LAST_IDX = CW'(PAYLOAD_BYTES - 1);

	xpr_pkg::phase_t  phase_q, phase_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [7:0]       good_q, good_d;
	logic [7:0]       block_q, block_d;
	logic [7:0]       compl_q, compl_d;
	logic [15:0]      crc_q, crc_d;
	logic [7:0]       sum_q, sum_d;
	logic [7:0]       trail_hi_q, trail_hi_d;
	logic             err_q, err_d;
	logic             out_valid_q;
	xpr_pkg::result_t out_q;
	xpr_pkg::result_t res;

	logic             fire;
	logic             pay_last;
	logic [7:0]       good_inc;
	logic [8:0]       compl_sum;
	logic             trail_ok;
	logic [2:0]       judged;
	logic             v_en;
	logic [2:0]       v_sel;

	assign cmd_ready    = !out_valid_q || result_ready;
	assign fire         = cmd_valid && cmd_ready;
	assign pay_last     = (cnt_q == LAST_IDX);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign good_inc  = good_q + 8'd1;
	assign compl_sum = {1'b0, block_q} + {1'b0, compl_q};
	assign trail_ok  = crc_mode ?
		((trail_hi_q == crc_q[15:8]) && (cmd.rx_byte == crc_q[7:0])) :
		(cmd.rx_byte == sum_q);

	always_comb begin
		if (err_q) begin
			judged = xpr_pkg::VERDICT_LINE;
		end else if (block_q == good_inc) begin
			judged = ((compl_sum == xpr_pkg::COMPL_SUM) && trail_ok) ?
				xpr_pkg::VERDICT_GOOD : xpr_pkg::VERDICT_BAD;
		end else if (block_q == good_q) begin
			judged = xpr_pkg::VERDICT_DUP;
		end else begin
			judged = xpr_pkg::VERDICT_BAD;
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		if (fire) begin
			unique case (cmd.kind)
				xpr_pkg::K_START, xpr_pkg::K_TIMEOUT: phase_d = xpr_pkg::PH_IDLE;
				xpr_pkg::K_LINE_ERR:                  phase_d = phase_q;
				xpr_pkg::K_BYTE: begin
					unique case (phase_q)
						xpr_pkg::PH_IDLE:     phase_d = cmd.is_soh ? xpr_pkg::PH_BLOCK :
							xpr_pkg::PH_IDLE;
						xpr_pkg::PH_BLOCK:    phase_d = xpr_pkg::PH_COMPL;
						xpr_pkg::PH_COMPL:    phase_d = xpr_pkg::PH_PAYLOAD;
						xpr_pkg::PH_PAYLOAD:  phase_d = pay_last ? xpr_pkg::PH_TRAIL_HI :
							xpr_pkg::PH_PAYLOAD;
						xpr_pkg::PH_TRAIL_HI: phase_d = crc_mode ? xpr_pkg::PH_TRAIL_LO :
							xpr_pkg::PH_IDLE;
						xpr_pkg::PH_TRAIL_LO: phase_d = xpr_pkg::PH_IDLE;
						default:              phase_d = xpr_pkg::PH_IDLE;
					endcase
				end
				default: phase_d = xpr_pkg::PH_IDLE;
			endcase
		end
	end

	// outputs and datapath
	always_comb begin
		res        = '0;
		cnt_d      = cnt_q;
		good_d     = good_q;
		block_d    = block_q;
		compl_d    = compl_q;
		crc_d      = crc_q;
		sum_d      = sum_q;
		trail_hi_d = trail_hi_q;
		err_d      = err_q;
		v_en       = 1'b0;
		v_sel      = xpr_pkg::VERDICT_GOOD;
		unique case (cmd.kind)
			xpr_pkg::K_START: begin
				good_d          = '0;
				err_d           = 1'b0;
				res.reply_valid = 1'b1;
				res.reply_code  = crc_mode ? xpr_pkg::SYM_CRC : xpr_pkg::SYM_NAK;
			end
			xpr_pkg::K_LINE_ERR: begin
				err_d = 1'b1;
			end
			xpr_pkg::K_TIMEOUT: begin
				v_en  = 1'b1;
				v_sel = xpr_pkg::VERDICT_TIMEOUT;
			end
			xpr_pkg::K_BYTE: begin
				unique case (phase_q)
					xpr_pkg::PH_IDLE: begin
						if (cmd.is_soh) begin
							crc_d = '0;
							sum_d = '0;
						end else begin
							v_en = 1'b1;
							if (err_q) begin
								v_sel = xpr_pkg::VERDICT_LINE;
							end else if (cmd.is_eot) begin
								v_sel = xpr_pkg::VERDICT_END;
							end else begin
								v_sel = xpr_pkg::VERDICT_BAD;
							end
						end
					end
					xpr_pkg::PH_BLOCK: begin
						block_d = cmd.rx_byte;
					end
					xpr_pkg::PH_COMPL: begin
						compl_d = cmd.rx_byte;
						cnt_d   = '0;
					end
					xpr_pkg::PH_PAYLOAD: begin
						res.payload_valid = 1'b1;
						res.payload_byte  = cmd.rx_byte;
						res.payload_index = cnt_q[6:0];
						crc_d             = xpr_pkg::crc16_byte(crc_q, cmd.rx_byte);
						sum_d             = sum_q + cmd.rx_byte;
						cnt_d             = cnt_q + 1'b1;
					end
					xpr_pkg::PH_TRAIL_HI: begin
						if (crc_mode) begin
							trail_hi_d = cmd.rx_byte;
						end else begin
							v_en  = 1'b1;
							v_sel = judged;
						end
					end
					xpr_pkg::PH_TRAIL_LO: begin
						v_en  = 1'b1;
						v_sel = judged;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		if (v_en) begin
			res.packet_done = 1'b1;
			res.verdict     = v_sel;
			res.reply_valid = 1'b1;
			res.reply_code  = (v_sel == xpr_pkg::VERDICT_GOOD || v_sel == xpr_pkg::VERDICT_DUP ||
				v_sel == xpr_pkg::VERDICT_END) ? xpr_pkg::SYM_ACK : xpr_pkg::SYM_NAK;
			err_d           = 1'b0;
			if (v_sel == xpr_pkg::VERDICT_GOOD) begin
				good_d = good_inc;
			end
		end
		res.last_block = good_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= xpr_pkg::PH_IDLE;
			cnt_q       <= '0;
			good_q      <= '0;
			block_q     <= '0;
			compl_q     <= '0;
			crc_q       <= '0;
			sum_q       <= '0;
			trail_hi_q  <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q    <= phase_d;
				cnt_q      <= cnt_d;
				good_q     <= good_d;
				block_q    <= block_d;
				compl_q    <= compl_d;
				crc_q      <= crc_d;
				sum_q      <= sum_d;
				trail_hi_q <= trail_hi_d;
				err_q      <= err_d;
			end
			if (cmd_ready) begin
				out_valid_q <= cmd_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res;
		end
	end

	`XPR_ASSERT_IMP(a_done_replies, clk, arst_n, out_valid_q && out_q.packet_done, out_q.reply_valid, "verdict without reply")
	`XPR_ASSERT_IMP(a_payload_no_done, clk, arst_n, out_valid_q && out_q.payload_valid, !out_q.packet_done, "payload byte carries a verdict")
	`XPR_ASSERT_NXT(a_timeout_idle, clk, arst_n, fire && cmd.kind == xpr_pkg::K_TIMEOUT, phase_q == xpr_pkg::PH_IDLE, "timeout left framing open")

endmodule
